// File: rtl/core/meadj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh edge adjacency table package
// Shared sizes, command and state codes, and request/result/entry types.
// ----------------------------------------------------------------------------
package meadj_pkg;

	localparam int MAX_EDGES   = 1024;
	localparam int SLOT_BITS   = $clog2(MAX_EDGES);
	localparam int COUNT_BITS  = $clog2(MAX_EDGES + 1);
	localparam int VERTEX_BITS = 16;
	localparam int FACET_BITS  = 16;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ
	} state_t;

	typedef struct packed {
		logic [1:0]             command;
		logic [VERTEX_BITS-1:0] vertex_a;
		logic [VERTEX_BITS-1:0] vertex_b;
		logic [FACET_BITS-1:0]  facet;
		logic [SLOT_BITS-1:0]   read_slot;
	} req_t;

	typedef struct packed {
		logic [SLOT_BITS-1:0]   edge_slot;
		logic                   is_new;
		logic                   dropped_full;
		logic [COUNT_BITS-1:0]  edge_total;
		logic [VERTEX_BITS-1:0] low_vertex;
		logic [VERTEX_BITS-1:0] high_vertex;
		logic [FACET_BITS-1:0]  first_facet;
		logic [FACET_BITS-1:0]  second_facet;
		logic                   second_valid;
	} rsp_t;

	typedef struct packed {
		logic [VERTEX_BITS-1:0] low_vertex;
		logic [VERTEX_BITS-1:0] high_vertex;
		logic [FACET_BITS-1:0]  first_facet;
		logic [FACET_BITS-1:0]  second_facet;
		logic                   second_valid;
	} entry_t;

endpackage

// File: rtl/core/meadj_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module meadj_mem (
	input  logic                            clk,
	input  logic                            we,
	input  logic [meadj_pkg::SLOT_BITS-1:0] waddr,
	input  meadj_pkg::entry_t               wdata,
	input  logic [meadj_pkg::SLOT_BITS-1:0] raddr,
	output meadj_pkg::entry_t               rdata
);

	meadj_pkg::entry_t mem_q [meadj_pkg::MAX_EDGES];
	meadj_pkg::entry_t rdata_q;

	// write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read one entry, data valid next cycle
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/mesh_edge_adjacency_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh edge adjacency table
// Stores undirected edges with the first and latest sharing facet; an add
// scans the stored entries one per cycle through a single compare unit.
// ----------------------------------------------------------------------------
//  channel   strobe/handshake        payload
//  request   start & !busy           req (req_t)
//  result    done, one cycle         rsp (rsp_t)
//
//  Add: accepted in idle, then the stored entries are scanned in order until a
//  match or the fill count (1024 at most); the scan loop over the memory read
//  port sets the length. An add to an empty table finishes at once.
//  Clear, unused commands and reads out of range finish at once.
//  Reset clears the fill count and the sequencer; entries need no clearing.
//  busy stays high while a scan or an in-range read is in work; results cannot be held off.
// ----------------------------------------------------------------------------
module mesh_edge_adjacency_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  meadj_pkg::req_t   req,
	output logic              done,
	output meadj_pkg::rsp_t   rsp
);

	localparam int SB = meadj_pkg::SLOT_BITS;
	localparam int CB = meadj_pkg::COUNT_BITS;
	localparam int VB = meadj_pkg::VERTEX_BITS;
	localparam int FB = meadj_pkg::FACET_BITS;

	meadj_pkg::state_t state_q, state_d;
	logic [CB-1:0]     count_q, count_d;
	logic [SB-1:0]     idx_q, idx_d;
	logic [VB-1:0]     key_lo_q, key_lo_d, key_hi_q, key_hi_d;
	logic [FB-1:0]     key_fc_q, key_fc_d;
	logic              done_q, done_d;
	meadj_pkg::rsp_t   rsp_q, rsp_d;

	logic              mem_we;
	logic [SB-1:0]     mem_waddr, mem_raddr;
	meadj_pkg::entry_t mem_wdata, mem_rdata;

	meadj_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// sequencer and shared compare unit
	always_comb begin
		logic          fin_add;
		logic [VB-1:0] k_lo, k_hi;
		logic [FB-1:0] k_fc;

		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		key_lo_d  = key_lo_q;
		key_hi_d  = key_hi_q;
		key_fc_d  = key_fc_q;
		done_d    = 1'b0;
		rsp_d     = '0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '0;
		mem_raddr = idx_q + SB'(1);
		fin_add   = 1'b0;
		k_lo      = key_lo_q;
		k_hi      = key_hi_q;
		k_fc      = key_fc_q;

		unique case (state_q)
			meadj_pkg::ST_IDLE: begin
				// order the pair, so an empty-table add can append at once
				k_lo = (req.vertex_a < req.vertex_b) ? req.vertex_a : req.vertex_b;
				k_hi = (req.vertex_a < req.vertex_b) ? req.vertex_b : req.vertex_a;
				k_fc = req.facet;
				mem_raddr = (req.command == meadj_pkg::CMD_READ) ? req.read_slot : '0;
				if (start) begin
					unique case (meadj_pkg::cmd_t'(req.command))
						meadj_pkg::CMD_ADD: begin
							key_lo_d = k_lo;
							key_hi_d = k_hi;
							key_fc_d = k_fc;
							if (count_q == '0) begin
								fin_add = 1'b1;
							end else begin
								idx_d   = '0;
								state_d = meadj_pkg::ST_SCAN;
							end
						end
						meadj_pkg::CMD_CLEAR: begin
							count_d = '0;
							done_d  = 1'b1;
						end
						meadj_pkg::CMD_READ: begin
							if ({1'b0, req.read_slot} < count_q) begin
								idx_d   = req.read_slot;
								state_d = meadj_pkg::ST_READ;
							end else begin
								done_d          = 1'b1;
								rsp_d.edge_slot = req.read_slot;
								rsp_d.edge_total = count_q;
							end
						end
						meadj_pkg::CMD_NONE: begin
							done_d           = 1'b1;
							rsp_d.edge_total = count_q;
						end
						default: ;
					endcase
				end
			end
			meadj_pkg::ST_SCAN: begin
				// compare the entry read last cycle, prefetch the next one
				if (mem_rdata.low_vertex == key_lo_q && mem_rdata.high_vertex == key_hi_q) begin
					mem_we                 = 1'b1;
					mem_waddr              = idx_q;
					mem_wdata              = mem_rdata;
					mem_wdata.second_facet = key_fc_q;
					mem_wdata.second_valid = 1'b1;
					done_d             = 1'b1;
					rsp_d.edge_slot    = idx_q;
					rsp_d.edge_total   = count_q;
					rsp_d.low_vertex   = mem_rdata.low_vertex;
					rsp_d.high_vertex  = mem_rdata.high_vertex;
					rsp_d.first_facet  = mem_rdata.first_facet;
					rsp_d.second_facet = key_fc_q;
					rsp_d.second_valid = 1'b1;
					state_d            = meadj_pkg::ST_IDLE;
				end else if ({1'b0, idx_q} + CB'(1) == count_q) begin
					fin_add = 1'b1;
				end else begin
					idx_d = idx_q + SB'(1);
				end
			end
			meadj_pkg::ST_READ: begin
				done_d             = 1'b1;
				rsp_d.edge_slot    = idx_q;
				rsp_d.edge_total   = count_q;
				rsp_d.low_vertex   = mem_rdata.low_vertex;
				rsp_d.high_vertex  = mem_rdata.high_vertex;
				rsp_d.first_facet  = mem_rdata.first_facet;
				rsp_d.second_facet = mem_rdata.second_facet;
				rsp_d.second_valid = mem_rdata.second_valid;
				state_d            = meadj_pkg::ST_IDLE;
			end
			default: state_d = meadj_pkg::ST_IDLE;
		endcase

		// append the unmatched edge, or drop it when the table is full
		if (fin_add) begin
			done_d            = 1'b1;
			state_d           = meadj_pkg::ST_IDLE;
			rsp_d.low_vertex  = k_lo;
			rsp_d.high_vertex = k_hi;
			rsp_d.first_facet = k_fc;
			if (count_q < CB'(meadj_pkg::MAX_EDGES)) begin
				mem_we                 = 1'b1;
				mem_waddr              = count_q[SB-1:0];
				mem_wdata.low_vertex   = k_lo;
				mem_wdata.high_vertex  = k_hi;
				mem_wdata.first_facet  = k_fc;
				count_d                = count_q + CB'(1);
				rsp_d.edge_slot        = count_q[SB-1:0];
				rsp_d.is_new           = 1'b1;
				rsp_d.edge_total       = count_q + CB'(1);
			end else begin
				rsp_d.dropped_full = 1'b1;
				rsp_d.edge_total   = count_q;
			end
		end
	end

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= meadj_pkg::ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	// hold key, scan index and result payload
	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		key_lo_q <= key_lo_d;
		key_hi_q <= key_hi_d;
		key_fc_q <= key_fc_d;
		rsp_q    <= rsp_d;
	end

	assign busy = (state_q != meadj_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CB'(meadj_pkg::MAX_EDGES))
		else $error("fill count above table depth");
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == meadj_pkg::ST_SCAN |-> {1'b0, idx_q} < count_q)
		else $error("scan index past fill count");
	a_new_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.is_new |-> rsp.edge_total == {1'b0, rsp.edge_slot} + CB'(1))
		else $error("appended slot does not match new count");
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.dropped_full |-> rsp.edge_total == CB'(meadj_pkg::MAX_EDGES))
		else $error("drop reported while table not full");
	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> !done)
		else $error("result raised while a scan starts");
`endif

endmodule
